// File: rtl/pdmq_pkg.sv
// Package for the per-destination message queue unit.
// Holds the request kinds, status codes, controller states and fixed field widths.
// No dependencies.
package pdmq_pkg;

    localparam int KIND_W   = 2;
    localparam int QID_W    = 4;
    localparam int SLOT_W   = 6;
    localparam int SENDER_W = 4;
    localparam int STATUS_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQUEUE = 2'd0,
        KIND_DEQUEUE = 2'd1,
        KIND_PEEK    = 2'd2,
        KIND_REMOVE  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QRD,
        ST_ENQ_LINK,
        ST_SRD,
        ST_WALK,
        ST_RM_FOUND,
        ST_RM_CLR,
        ST_DONE
    } state_t;

endpackage

// File: rtl/per_destination_message_queues_unit.sv
// Per-destination message queue unit: FIFO queues linked through a shared slot pool.
// Top level; holds the queue memory, the slot memory and the controller.
// Depends on pdmq_pkg.
//
// One request is taken at a time and answered with exactly one result transaction.
// A remove whose named slot is not the head walks the links behind the head to find
// it. The slot memory has one read and one write port and a synchronous read: the
// remove walk follows one link per cycle through it. The next request is accepted in
// the cycle after the result is loaded into the output register, even while
// that result still waits for out_ready. Per-queue head and tail pointers live in a
// synchronous queue memory whose entries read as empty until first written (valid
// bits cleared by reset, so no clearing pass is needed). Slot link and sender fields
// are undefined until a slot is enqueued; never dequeue, peek or remove through a slot
// that was never enqueued.
module per_destination_message_queues_unit #(
    parameter int NUM_QUEUES = 16,
    parameter int NUM_SLOTS  = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [pdmq_pkg::KIND_W-1:0]   kind,
    input  logic [pdmq_pkg::QID_W-1:0]    queue_id,
    input  logic [pdmq_pkg::SLOT_W-1:0]   slot,
    input  logic [pdmq_pkg::SENDER_W-1:0] sender,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pdmq_pkg::STATUS_W-1:0] status,
    output logic [pdmq_pkg::SLOT_W-1:0]   out_slot,
    output logic [pdmq_pkg::SENDER_W-1:0] out_sender
);

    // Pointer width holds every slot index plus the null value NUM_SLOTS.
    localparam int PTR_W  = $clog2(NUM_SLOTS + 1);
    localparam int SIDX_W = $clog2(NUM_SLOTS);
    localparam int QIDX_W = $clog2(NUM_QUEUES);
    localparam int STEP_W = $clog2(NUM_SLOTS);
    localparam logic [PTR_W-1:0]  NIL       = PTR_W'(NUM_SLOTS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_SLOTS - 1);

    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
    } qent_t;

    typedef struct packed {
        logic [PTR_W-1:0]              link;
        logic [pdmq_pkg::SENDER_W-1:0] snd;
    } sent_t;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    qent_t qmem [NUM_QUEUES];
    sent_t smem [NUM_SLOTS];

    qent_t q_rdata;
    sent_t s_rdata;

    logic                          q_rd_en;
    logic [QIDX_W-1:0]             q_raddr;
    logic                          q_we;
    qent_t                         q_wdata;
    logic                          s_rd_en;
    logic [SIDX_W-1:0]             s_raddr;
    logic                          s_we_link;
    logic                          s_we_snd;
    logic [SIDX_W-1:0]             s_waddr;
    logic [PTR_W-1:0]              s_wlink;
    logic [pdmq_pkg::SENDER_W-1:0] s_wsnd;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    pdmq_pkg::state_t              state_reg, state_next;
    pdmq_pkg::kind_t               kind_reg, kind_next;
    logic [QIDX_W-1:0]             q_reg, q_next;
    logic                          qok_reg, qok_next;
    logic                          sok_reg, sok_next;
    logic [PTR_W-1:0]              slot_reg, slot_next;
    logic [pdmq_pkg::SENDER_W-1:0] sender_reg, sender_next;
    logic [PTR_W-1:0]              h_reg, h_next;
    logic [PTR_W-1:0]              t_reg, t_next;
    logic [PTR_W-1:0]              prev_reg, prev_next;
    logic [STEP_W-1:0]             steps_reg, steps_next;
    pdmq_pkg::status_t             res_status_reg, res_status_next;
    logic [PTR_W-1:0]              res_slot_reg, res_slot_next;
    logic [pdmq_pkg::SENDER_W-1:0] res_sender_reg, res_sender_next;
    logic [NUM_QUEUES-1:0]         qvalid_reg;

    logic                          out_valid_reg;
    pdmq_pkg::status_t             status_reg;
    logic [pdmq_pkg::SLOT_W-1:0]   out_slot_reg;
    logic [pdmq_pkg::SENDER_W-1:0] out_sender_reg;
    logic                          out_load;

    logic [PTR_W-1:0]              h_cur;
    logic [PTR_W-1:0]              t_cur;
    logic [PTR_W-1:0]              cur;

    // Queue memory: one synchronous read port, one write port.
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            qmem[q_reg] <= q_wdata;
        end
        if (q_rd_en)
        begin
            q_rdata <= qmem[q_raddr];
        end
    end

    // Slot memory: link and sender fields carry separate write enables.
    always_ff @(posedge clk)
    begin
        if (s_we_link)
        begin
            smem[s_waddr].link <= s_wlink;
        end
        if (s_we_snd)
        begin
            smem[s_waddr].snd <= s_wsnd;
        end
        if (s_rd_en)
        begin
            s_rdata <= smem[s_raddr];
        end
    end

    // A queue entry that was never written reads as empty.
    assign h_cur = (qok_reg && qvalid_reg[q_reg]) ? q_rdata.head : NIL;
    assign t_cur = (qok_reg && qvalid_reg[q_reg]) ? q_rdata.tail : NIL;
    assign cur   = s_rdata.link;

    // ------------------------------------------------------------------
    // Controller state and request registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pdmq_pkg::ST_IDLE;
            qvalid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_we)
            begin
                qvalid_reg[q_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        q_reg          <= q_next;
        qok_reg        <= qok_next;
        sok_reg        <= sok_next;
        slot_reg       <= slot_next;
        sender_reg     <= sender_next;
        h_reg          <= h_next;
        t_reg          <= t_next;
        prev_reg       <= prev_next;
        steps_reg      <= steps_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_sender_reg <= res_sender_next;
    end

    // ------------------------------------------------------------------
    // Next state and memory controls
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        q_next          = q_reg;
        qok_next        = qok_reg;
        sok_next        = sok_reg;
        slot_next       = slot_reg;
        sender_next     = sender_reg;
        h_next          = h_reg;
        t_next          = t_reg;
        prev_next       = prev_reg;
        steps_next      = steps_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_sender_next = res_sender_reg;

        q_rd_en   = 1'b0;
        q_raddr   = QIDX_W'(queue_id);
        q_we      = 1'b0;
        q_wdata   = '{head: h_reg, tail: t_reg};
        s_rd_en   = 1'b0;
        s_raddr   = h_cur[SIDX_W-1:0];
        s_we_link = 1'b0;
        s_we_snd  = 1'b0;
        s_waddr   = slot_reg[SIDX_W-1:0];
        s_wlink   = NIL;
        s_wsnd    = sender_reg;
        out_load  = 1'b0;

        unique case (state_reg)
            pdmq_pkg::ST_IDLE:
            begin
                // Latch the transaction and fetch the queue's head and tail.
                if (in_valid)
                begin
                    kind_next       = pdmq_pkg::kind_t'(kind);
                    q_next          = QIDX_W'(queue_id);
                    qok_next        = 32'(queue_id) < NUM_QUEUES;
                    sok_next        = 32'(slot) < NUM_SLOTS;
                    slot_next       = PTR_W'(slot);
                    sender_next     = sender;
                    res_status_next = pdmq_pkg::STATUS_OK;
                    res_slot_next   = '0;
                    res_sender_next = '0;
                    q_rd_en         = 1'b1;
                    state_next      = pdmq_pkg::ST_QRD;
                end
            end

            pdmq_pkg::ST_QRD:
            begin
                h_next = h_cur;
                t_next = t_cur;
                unique case (kind_reg) inside
                    pdmq_pkg::KIND_ENQUEUE:
                    begin
                        if (!sok_reg)
                        begin
                            res_status_next = pdmq_pkg::STATUS_NOT_FOUND;
                            state_next      = pdmq_pkg::ST_DONE;
                        end
                        else if (!qok_reg)
                        begin
                            state_next = pdmq_pkg::ST_DONE;
                        end
                        else
                        begin
                            // New slot becomes the tail with a null link.
                            s_we_link    = 1'b1;
                            s_we_snd     = 1'b1;
                            s_wlink      = NIL;
                            q_we         = 1'b1;
                            q_wdata.tail = slot_reg;
                            if (h_cur == NIL || t_cur == NIL)
                            begin
                                q_wdata.head = slot_reg;
                                state_next   = pdmq_pkg::ST_DONE;
                            end
                            else
                            begin
                                q_wdata.head = h_cur;
                                state_next   = pdmq_pkg::ST_ENQ_LINK;
                            end
                        end
                    end

                    pdmq_pkg::KIND_DEQUEUE, pdmq_pkg::KIND_PEEK:
                    begin
                        if (h_cur >= NIL)
                        begin
                            res_status_next = pdmq_pkg::STATUS_EMPTY;
                            state_next      = pdmq_pkg::ST_DONE;
                        end
                        else
                        begin
                            s_rd_en    = 1'b1;
                            state_next = pdmq_pkg::ST_SRD;
                        end
                    end

                    pdmq_pkg::KIND_REMOVE:
                    begin
                        if (h_cur >= NIL)
                        begin
                            res_status_next = pdmq_pkg::STATUS_EMPTY;
                            state_next      = pdmq_pkg::ST_DONE;
                        end
                        else if (!sok_reg)
                        begin
                            res_status_next = pdmq_pkg::STATUS_NOT_FOUND;
                            state_next      = pdmq_pkg::ST_DONE;
                        end
                        else if (h_cur == slot_reg)
                        begin
                            // Removing the head unlinks like a dequeue.
                            s_rd_en    = 1'b1;
                            state_next = pdmq_pkg::ST_SRD;
                        end
                        else
                        begin
                            s_rd_en    = 1'b1;
                            prev_next  = h_cur;
                            steps_next = '0;
                            state_next = pdmq_pkg::ST_WALK;
                        end
                    end

                    default:
                    begin
                        state_next = pdmq_pkg::ST_DONE;
                    end
                endcase
            end

            pdmq_pkg::ST_ENQ_LINK:
            begin
                // Hook the new slot behind the old tail.
                s_we_link  = 1'b1;
                s_waddr    = t_reg[SIDX_W-1:0];
                s_wlink    = slot_reg;
                state_next = pdmq_pkg::ST_DONE;
            end

            pdmq_pkg::ST_SRD:
            begin
                if (kind_reg != pdmq_pkg::KIND_PEEK)
                begin
                    // Advance the head and drop the old head's link.
                    q_we         = 1'b1;
                    q_wdata.head = cur;
                    q_wdata.tail = (cur == NIL) ? NIL : t_reg;
                    s_we_link    = 1'b1;
                    s_waddr      = h_reg[SIDX_W-1:0];
                    s_wlink      = NIL;
                end
                if (kind_reg != pdmq_pkg::KIND_REMOVE)
                begin
                    res_slot_next   = h_reg;
                    res_sender_next = s_rdata.snd;
                end
                state_next = pdmq_pkg::ST_DONE;
            end

            pdmq_pkg::ST_WALK:
            begin
                // Follow one link per cycle looking for the named slot.
                s_raddr = cur[SIDX_W-1:0];
                if (cur == NIL)
                begin
                    res_status_next = pdmq_pkg::STATUS_NOT_FOUND;
                    state_next      = pdmq_pkg::ST_DONE;
                end
                else if (cur == slot_reg)
                begin
                    s_rd_en    = 1'b1;
                    state_next = pdmq_pkg::ST_RM_FOUND;
                end
                else if (steps_reg == STEP_LAST)
                begin
                    res_status_next = pdmq_pkg::STATUS_NOT_FOUND;
                    state_next      = pdmq_pkg::ST_DONE;
                end
                else
                begin
                    s_rd_en    = 1'b1;
                    prev_next  = cur;
                    steps_next = steps_reg + 1'b1;
                end
            end

            pdmq_pkg::ST_RM_FOUND:
            begin
                // Bypass the removed slot; pull the tail back if it was the tail.
                s_we_link = 1'b1;
                s_waddr   = prev_reg[SIDX_W-1:0];
                s_wlink   = cur;
                if (t_reg == slot_reg)
                begin
                    q_we         = 1'b1;
                    q_wdata.head = h_reg;
                    q_wdata.tail = prev_reg;
                end
                state_next = pdmq_pkg::ST_RM_CLR;
            end

            pdmq_pkg::ST_RM_CLR:
            begin
                s_we_link  = 1'b1;
                s_wlink    = NIL;
                state_next = pdmq_pkg::ST_DONE;
            end

            pdmq_pkg::ST_DONE:
            begin
                // Hold the result until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = pdmq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pdmq_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg     <= res_status_reg;
            out_slot_reg   <= pdmq_pkg::SLOT_W'(res_slot_reg);
            out_sender_reg <= res_sender_reg;
        end
    end

    assign in_ready   = (state_reg == pdmq_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign out_slot   = out_slot_reg;
    assign out_sender = out_sender_reg;

endmodule

// File: rtl/pdmq_checker.sv
// Port-level checker for the per-destination message queue unit, and its bind.
// Watches only the top level's ports.
// Depends on pdmq_pkg and per_destination_message_queues_unit.
module pdmq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [pdmq_pkg::KIND_W-1:0]   kind,
    input logic [pdmq_pkg::QID_W-1:0]    queue_id,
    input logic [pdmq_pkg::SLOT_W-1:0]   slot,
    input logic [pdmq_pkg::SENDER_W-1:0] sender,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [pdmq_pkg::STATUS_W-1:0] status,
    input logic [pdmq_pkg::SLOT_W-1:0]   out_slot,
    input logic [pdmq_pkg::SENDER_W-1:0] out_sender
);

    // Hold a stalled result unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(out_slot) && $stable(out_sender))
        else $error("stalled result changed");

    // A failed request carries no slot or sender.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != pdmq_pkg::STATUS_OK |-> out_slot == '0 && out_sender == '0)
        else $error("failed request returned a slot");

    // An accepted transaction occupies the block for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after acceptance");

    // An enqueue accepted while no result is pending does not report an empty queue.
    a_enq_never_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == pdmq_pkg::KIND_ENQUEUE && !out_valid
            |=> ##2 !(out_valid && status == pdmq_pkg::STATUS_EMPTY))
        else $error("enqueue answered queue empty");

endmodule

bind per_destination_message_queues_unit pdmq_checker u_pdmq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .queue_id   (queue_id),
    .slot       (slot),
    .sender     (sender),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .out_slot   (out_slot),
    .out_sender (out_sender)
);
